// ===== hw/rtl/dtq_pkg.sv =====
// ----------------------------------------------------------------------------
// dtq_pkg
// Shared types and constants of the delta-list timer queue: command and
// status codes, controller states and the command and status groups that
// join the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package dtq_pkg;

  localparam int DefDepth      = 16;
  localparam int DefDelayWidth = 16;
  localparam int MaxResults    = 16;
  localparam int NumW          = $clog2(MaxResults + 1);

  localparam int CmdW    = 2;
  localparam int TaskW   = 8;
  localparam int SemW    = 6;
  localparam int DelayW  = 16;
  localparam int StatusW = 3;

  typedef enum logic [CmdW-1:0] {
    CmdInsert = 2'd0,
    CmdTake   = 2'd1,
    CmdTick   = 2'd2,
    CmdNone   = 2'd3
  } dtq_cmd_e;

  typedef enum logic [StatusW-1:0] {
    StInserted = 3'd0,
    StFull     = 3'd1,
    StEmpty    = 3'd2,
    StExpired  = 3'd3,
    StTaken    = 3'd4
  } dtq_status_e;

  typedef enum logic [2:0] {
    OpNone,
    OpFull,
    OpEmpty,
    OpTake,
    OpStep,
    OpInsert,
    OpDec,
    OpExpire
  } dtq_op_e;

  typedef enum logic [1:0] {
    FsmIdle,
    FsmWalk,
    FsmTick,
    FsmEmit
  } dtq_state_e;

  typedef struct packed {
    logic    load;
    dtq_op_e op;
  } dtq_ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic walk_done;
    logic expire_ok;
    logic out_last;
  } dtq_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dtq_ctrl.sv =====
// ----------------------------------------------------------------------------
// dtq_ctrl
// Controller of the timer queue. It accepts one request at a time, steers
// the insert walk and the expiry loop, and holds each result until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module dtq_ctrl (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [dtq_pkg::CmdW-1:0]     cmd_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  input  wire dtq_pkg::dtq_stat_t           stat_i,
  output dtq_pkg::dtq_ctrl_t                ctrl_o
);

  dtq_pkg::dtq_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dtq_pkg::FsmIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    ctrl_o.load  = 1'b0;
    ctrl_o.op    = dtq_pkg::OpNone;
    in_ready_o   = 1'b0;
    out_valid_o  = 1'b0;
    unique case (state_q)
      dtq_pkg::FsmIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.load = 1'b1;
          unique case (dtq_pkg::dtq_cmd_e'(cmd_i))
            dtq_pkg::CmdInsert: begin
              if (stat_i.full) begin
                ctrl_o.op = dtq_pkg::OpFull;
                state_d   = dtq_pkg::FsmEmit;
              end else begin
                state_d = dtq_pkg::FsmWalk;
              end
            end
            dtq_pkg::CmdTake: begin
              ctrl_o.op = stat_i.empty ? dtq_pkg::OpEmpty : dtq_pkg::OpTake;
              state_d   = dtq_pkg::FsmEmit;
            end
            dtq_pkg::CmdTick: begin
              if (!stat_i.empty) begin
                ctrl_o.op = dtq_pkg::OpDec;
                state_d   = dtq_pkg::FsmTick;
              end
            end
            default: begin
              state_d = dtq_pkg::FsmIdle;
            end
          endcase
        end
      end
      dtq_pkg::FsmWalk: begin
        if (stat_i.walk_done) begin
          ctrl_o.op = dtq_pkg::OpInsert;
          state_d   = dtq_pkg::FsmEmit;
        end else begin
          ctrl_o.op = dtq_pkg::OpStep;
        end
      end
      dtq_pkg::FsmTick: begin
        if (stat_i.expire_ok) begin
          ctrl_o.op = dtq_pkg::OpExpire;
          state_d   = dtq_pkg::FsmEmit;
        end else begin
          state_d = dtq_pkg::FsmIdle;
        end
      end
      dtq_pkg::FsmEmit: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = stat_i.out_last ? dtq_pkg::FsmIdle : dtq_pkg::FsmTick;
        end
      end
      default: begin
        state_d = dtq_pkg::FsmIdle;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dtq_datapath.sv =====
// ----------------------------------------------------------------------------
// dtq_datapath
// Entry store of the delta list, the insert walk registers, the expiry
// counter and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dtq_datapath #(
  parameter int DEPTH       = dtq_pkg::DefDepth,
  parameter int DELAY_WIDTH = dtq_pkg::DefDelayWidth
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic [dtq_pkg::TaskW-1:0]       task_id_i,
  input  wire logic [dtq_pkg::SemW-1:0]        sem_id_i,
  input  wire logic [dtq_pkg::DelayW-1:0]      delay_i,
  input  wire dtq_pkg::dtq_ctrl_t              ctrl_i,
  output dtq_pkg::dtq_stat_t                   stat_o,
  output logic [dtq_pkg::StatusW-1:0]          status_o,
  output logic [dtq_pkg::TaskW-1:0]            task_id_out_o,
  output logic [dtq_pkg::SemW-1:0]             sem_id_out_o,
  output logic                                 last_o
);

  localparam int IdxW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);
  localparam int DW   = DELAY_WIDTH;

  logic [dtq_pkg::TaskW-1:0] task_q  [DEPTH];
  logic [dtq_pkg::SemW-1:0]  sem_q   [DEPTH];
  logic [DW-1:0]             delta_q [DEPTH];

  logic [CntW-1:0]            count_q, count_d;
  logic [CntW-1:0]            idx_q;
  logic [DW-1:0]              rem_q;
  logic [dtq_pkg::NumW-1:0]   num_q;
  logic [dtq_pkg::TaskW-1:0]  task_in_q;
  logic [dtq_pkg::SemW-1:0]   sem_in_q;

  logic [DW+dtq_pkg::DelayW-1:0] delay_ext;
  logic [DW-1:0]                 rem_init;
  logic [DW-1:0]                 delta_at_idx;
  logic [DW:0]                   take_sum;
  logic [DW-1:0]                 take_sat;
  logic                          next_expires;

  assign delay_ext    = {{DW{1'b0}}, delay_i};
  assign rem_init     = (delay_ext[DW-1:0] == '0) ? DW'(1) : delay_ext[DW-1:0];
  assign delta_at_idx = delta_q[idx_q[IdxW-1:0]];
  assign take_sum     = {1'b0, delta_q[1]} + {1'b0, delta_q[0]};
  assign take_sat     = take_sum[DW] ? {DW{1'b1}} : take_sum[DW-1:0];
  assign next_expires = (count_q > CntW'(1)) && (delta_q[1] == '0) &&
                        ((num_q + dtq_pkg::NumW'(1)) < dtq_pkg::NumW'(dtq_pkg::MaxResults));

  assign stat_o.empty     = (count_q == '0);
  assign stat_o.full      = (count_q >= CntW'(DEPTH));
  assign stat_o.walk_done = !((idx_q < count_q) && (delta_at_idx <= rem_q));
  assign stat_o.expire_ok = (count_q != '0) && (delta_q[0] == '0) &&
                            (num_q < dtq_pkg::NumW'(dtq_pkg::MaxResults));
  assign stat_o.out_last  = last_o;

  always_comb begin
    count_d = count_q;
    unique case (ctrl_i.op)
      dtq_pkg::OpInsert:                   count_d = count_q + CntW'(1);
      dtq_pkg::OpTake, dtq_pkg::OpExpire:  count_d = count_q - CntW'(1);
      default:                             count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      task_in_q <= task_id_i;
      sem_in_q  <= sem_id_i;
      rem_q     <= rem_init;
      idx_q     <= '0;
      num_q     <= '0;
    end else if (ctrl_i.op == dtq_pkg::OpStep) begin
      rem_q <= rem_q - delta_at_idx;
      idx_q <= idx_q + CntW'(1);
    end else if (ctrl_i.op == dtq_pkg::OpExpire) begin
      num_q <= num_q + dtq_pkg::NumW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.op)
      dtq_pkg::OpTake, dtq_pkg::OpExpire: begin
        for (int i = 0; i < DEPTH - 1; i++) begin
          task_q[i]  <= task_q[i+1];
          sem_q[i]   <= sem_q[i+1];
          delta_q[i] <= delta_q[i+1];
        end
        if (ctrl_i.op == dtq_pkg::OpTake) begin
          delta_q[0] <= take_sat;
        end
      end
      dtq_pkg::OpInsert: begin
        for (int i = 1; i < DEPTH; i++) begin
          if ((CntW'(i) > idx_q) && (CntW'(i) <= count_q)) begin
            task_q[i]  <= task_q[i-1];
            sem_q[i]   <= sem_q[i-1];
            delta_q[i] <= (CntW'(i) == idx_q + CntW'(1)) ? delta_q[i-1] - rem_q
                                                          : delta_q[i-1];
          end
        end
        task_q[idx_q[IdxW-1:0]]  <= task_in_q;
        sem_q[idx_q[IdxW-1:0]]   <= sem_in_q;
        delta_q[idx_q[IdxW-1:0]] <= rem_q;
      end
      dtq_pkg::OpDec: begin
        if (delta_q[0] != '0) begin
          delta_q[0] <= delta_q[0] - DW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.op)
      dtq_pkg::OpFull: begin
        status_o      <= dtq_pkg::StFull;
        task_id_out_o <= '0;
        sem_id_out_o  <= '0;
        last_o        <= 1'b1;
      end
      dtq_pkg::OpEmpty: begin
        status_o      <= dtq_pkg::StEmpty;
        task_id_out_o <= '0;
        sem_id_out_o  <= '0;
        last_o        <= 1'b1;
      end
      dtq_pkg::OpInsert: begin
        status_o      <= dtq_pkg::StInserted;
        task_id_out_o <= '0;
        sem_id_out_o  <= '0;
        last_o        <= 1'b1;
      end
      dtq_pkg::OpTake: begin
        status_o      <= dtq_pkg::StTaken;
        task_id_out_o <= task_q[0];
        sem_id_out_o  <= sem_q[0];
        last_o        <= 1'b1;
      end
      dtq_pkg::OpExpire: begin
        status_o      <= dtq_pkg::StExpired;
        task_id_out_o <= task_q[0];
        sem_id_out_o  <= sem_q[0];
        last_o        <= !next_expires;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/delta_timer_queue_unit.sv =====
// ----------------------------------------------------------------------------
// delta_timer_queue_unit
// Take and full or empty answers are registered as the request is accepted.
// An insert walks past the entries whose deltas fit in its remaining delay
// (up to DEPTH - 1), then stores itself. A tick on a non-empty queue lowers the
// head delta, then emits expired head entries, each after the last is taken.
// A tick that expires nothing gives no result. One request at a time.
// Reset clears the entry count and the controller; entry contents stay as is.
// ----------------------------------------------------------------------------
`default_nettype none

module delta_timer_queue_unit #(
  parameter int DEPTH       = dtq_pkg::DefDepth,
  parameter int DELAY_WIDTH = dtq_pkg::DefDelayWidth
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [dtq_pkg::CmdW-1:0]      cmd_i,
  input  wire logic [dtq_pkg::TaskW-1:0]     task_id_i,
  input  wire logic [dtq_pkg::SemW-1:0]      sem_id_i,
  input  wire logic [dtq_pkg::DelayW-1:0]    delay_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [dtq_pkg::StatusW-1:0]        status_o,
  output logic [dtq_pkg::TaskW-1:0]          task_id_out_o,
  output logic [dtq_pkg::SemW-1:0]           sem_id_out_o,
  output logic                               last_o
);

  dtq_pkg::dtq_ctrl_t ctrl;
  dtq_pkg::dtq_stat_t stat;

  dtq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  dtq_datapath #(
    .DEPTH       (DEPTH),
    .DELAY_WIDTH (DELAY_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .task_id_i     (task_id_i),
    .sem_id_i      (sem_id_i),
    .delay_i       (delay_i),
    .ctrl_i        (ctrl),
    .stat_o        (stat),
    .status_o      (status_o),
    .task_id_out_o (task_id_out_o),
    .sem_id_out_o  (sem_id_out_o),
    .last_o        (last_o)
  );

endmodule

`default_nettype wire
